// ----- rtl/i2cs_pkg.sv -----
`timescale 1ns / 1ps

package i2cs_pkg;

  localparam int LEN_WIDTH   = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] ADDR_MASK = 7'h7F;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_RECV  = 2'd1,
    OP_EVENT = 2'd2,
    OP_ERROR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_TX    = 2'd1,
    ST_RX    = 2'd2
  } xfer_state_e;

  // interrupt enable bits
  localparam int EN_EVT = 0;
  localparam int EN_BUF = 1;
  localparam int EN_ERR = 2;

  typedef struct packed {
    logic start_sent;
    logic addr_sent;
    logic stop_det;
    logic byte_done;
    logic rx_not_empty;
    logic tx_empty;
  } evt_t;

  typedef struct packed {
    op_e                  op;
    logic [LEN_WIDTH-1:0] len;
    logic [6:0]           addr;
    logic                 rep_start;
    evt_t                 evt;
    logic [4:0]           err;
    logic                 master;
    logic                 transmitter;
    logic [7:0]           tx_data;
    logic [7:0]           rx_data;
  } item_t;

  typedef struct packed {
    logic [2:0]  irq_enables;
    logic [9:0]  app_events;
    logic [7:0]  rx_byte;
    logic        rx_byte_valid;
    logic        ack_bit;
    logic        gen_stop;
    logic        gen_start;
    logic [7:0]  data_write;
    logic        data_write_valid;
    logic [1:0]  prior_state;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/i2cs_front.sv -----
`timescale 1ns / 1ps

module i2cs_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // length[15:0], slave_addr[22:16], repeated_start[23], event_flags[29:24],
  // error_flags[34:30], master_mode[35], transmitter_mode[36], tx_data[44:37],
  // rx_data[52:45]
  input  logic [55:0]       s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]        s_axis_tuser,
  input  i2cs_pkg::q_status_t q_status_i,
  output logic              push_o,
  output i2cs_pkg::item_t   item_o
);
  import i2cs_pkg::*;

  logic [15:0] len_raw;

  assign s_axis_tready = ~q_status_i.full;
  assign push_o        = s_axis_tvalid & ~q_status_i.full;
  assign len_raw       = s_axis_tdata[15:0];

  always_comb begin
    item_o.op          = op_e'(s_axis_tuser);
    item_o.len         = LEN_WIDTH'(len_raw);
    item_o.addr        = s_axis_tdata[22:16] & ADDR_MASK;
    item_o.rep_start   = s_axis_tdata[23];
    item_o.evt         = evt_t'({s_axis_tdata[24], s_axis_tdata[25], s_axis_tdata[26],
                                 s_axis_tdata[27], s_axis_tdata[28], s_axis_tdata[29]});
    item_o.err         = s_axis_tdata[34:30];
    item_o.master      = s_axis_tdata[35];
    item_o.transmitter = s_axis_tdata[36];
    item_o.tx_data     = s_axis_tdata[44:37];
    item_o.rx_data     = s_axis_tdata[52:45];
  end

endmodule

// ----- rtl/i2cs_queue.sv -----
`timescale 1ns / 1ps

module i2cs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  i2cs_pkg::item_t     item_i,
  input  logic                pop_i,
  output i2cs_pkg::item_t     item_o,
  output i2cs_pkg::q_status_t status_o
);
  import i2cs_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign item_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wrap_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? wrap_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/i2cs_exec.sv -----
`timescale 1ns / 1ps

module i2cs_exec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  i2cs_pkg::q_status_t q_status_i,
  input  i2cs_pkg::item_t     item_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output i2cs_pkg::result_t   result_o
);
  import i2cs_pkg::*;

  localparam logic [LEN_WIDTH-1:0] ONE = LEN_WIDTH'(1);
  localparam logic [LEN_WIDTH-1:0] TWO = LEN_WIDTH'(2);

  xfer_state_e          st_q, st_d;
  logic [LEN_WIDTH-1:0] rem_q, rem_d;
  logic [LEN_WIDTH-1:0] tot_q, tot_d;
  logic [6:0]           addr_q, addr_d;
  logic                 keep_q, keep_d;
  logic                 ack_q, ack_d;
  logic [2:0]           en_q, en_d;
  logic                 ack_en_q;
  logic                 out_valid_q;
  result_t              res_q, res_d;
  logic                 fire;

  assign fire          = ~q_status_i.empty & (~out_valid_q | m_axis_tready);
  assign pop_o         = fire;
  assign m_axis_tvalid = out_valid_q;
  assign result_o      = res_q;

  always_comb begin
    st_d   = st_q;
    rem_d  = rem_q;
    tot_d  = tot_q;
    addr_d = addr_q;
    keep_d = keep_q;
    ack_d  = ack_q;
    en_d   = en_q;
    res_d  = '0;
    res_d.prior_state = st_q;

    case (item_i.op)
      OP_SEND, OP_RECV: begin
        if (st_q != ST_TX && st_q != ST_RX) begin
          rem_d = item_i.len;
          if (item_i.op == OP_RECV) begin
            tot_d = item_i.len;
          end
          addr_d = item_i.addr;
          keep_d = item_i.rep_start;
          st_d   = (item_i.op == OP_SEND) ? ST_TX : ST_RX;
          res_d.gen_start = 1'b1;
          en_d   = 3'b111;
        end
      end
      OP_EVENT: begin
        if (en_d[EN_EVT]) begin
          if (item_i.evt.start_sent) begin
            res_d.data_write_valid = 1'b1;
            res_d.data_write = {addr_d, (st_d == ST_RX)};
          end
          if (item_i.evt.addr_sent && item_i.master && st_d == ST_RX && rem_d == ONE) begin
            ack_d = 1'b0;
          end
          if (item_i.evt.stop_det && st_d == ST_RX) begin
            res_d.app_events[4] = 1'b1;
          end
          if (item_i.evt.byte_done && st_d == ST_TX && rem_d == '0) begin
            if (!keep_d) begin
              res_d.gen_stop = 1'b1;
            end
            en_d  = '0;
            rem_d = '0;
            st_d  = ST_READY;
            res_d.app_events[0] = 1'b1;
          end
          if (en_d[EN_BUF]) begin
            if (item_i.evt.rx_not_empty) begin
              if (item_i.master) begin
                if (st_d == ST_RX) begin
                  if (tot_d == ONE) begin
                    if (!keep_d) begin
                      res_d.gen_stop = 1'b1;
                    end
                    res_d.rx_byte_valid = 1'b1;
                    res_d.rx_byte = item_i.rx_data;
                    if (rem_d != '0) begin
                      rem_d = rem_d - ONE;
                    end
                  end else if (tot_d > ONE && rem_d != '0) begin
                    if (rem_d == TWO) begin
                      ack_d = 1'b0;
                    end
                    res_d.rx_byte_valid = 1'b1;
                    res_d.rx_byte = item_i.rx_data;
                    rem_d = rem_d - ONE;
                  end
                  if (rem_d == '0) begin
                    if (!keep_d) begin
                      res_d.gen_stop = 1'b1;
                    end
                    en_d  = '0;
                    rem_d = '0;
                    tot_d = '0;
                    st_d  = ST_READY;
                    if (ack_en_q) begin
                      ack_d = 1'b1;
                    end
                    res_d.app_events[1] = 1'b1;
                  end
                end
              end else if (!item_i.transmitter) begin
                res_d.app_events[3] = 1'b1;
              end
            end
            if (item_i.evt.tx_empty) begin
              if (item_i.master) begin
                if (st_d == ST_TX && rem_d != '0) begin
                  res_d.data_write_valid = 1'b1;
                  res_d.data_write = item_i.tx_data;
                  rem_d = rem_d - ONE;
                end
              end else if (item_i.transmitter) begin
                res_d.app_events[2] = 1'b1;
              end
            end
          end
        end
      end
      OP_ERROR: begin
        if (en_d[EN_ERR]) begin
          res_d.app_events[9:5] = item_i.err;
        end
      end
      default: begin
      end
    endcase

    res_d.ack_bit     = ack_d;
    res_d.irq_enables = en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_READY;
      rem_q       <= '0;
      tot_q       <= '0;
      addr_q      <= '0;
      keep_q      <= 1'b0;
      ack_q       <= 1'b1;
      en_q        <= '0;
      ack_en_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ack_en_q <= cfg_wdata_i;
      end
      if (fire) begin
        st_q   <= st_d;
        rem_q  <= rem_d;
        tot_q  <= tot_d;
        addr_q <= addr_d;
        keep_q <= keep_d;
        ack_q  <= ack_d;
        en_q   <= en_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

endmodule

// ----- rtl/i2c_interrupt_transfer_sequencer.sv -----
`timescale 1ns / 1ps
// A request accepted at the input is written into the queue; the execute stage then
// loads its result into the output register, from which the result is offered.
// Throughput: one request per cycle while m_axis_tready takes each result; the transfer
// registers in the execute stage are updated each time a request is executed.
// Reset: transfer ready, counters and address clear, ack level 1, ack_enable 1,
// interrupts off, queue and output empty.

module i2c_interrupt_transfer_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // length[15:0], slave_addr[22:16], repeated_start[23], event_flags[29:24],
  // error_flags[34:30], master_mode[35], transmitter_mode[36], tx_data[44:37],
  // rx_data[52:45]
  input  logic [55:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // prior_state[1:0], data_write_valid[2], data_write[10:3], gen_start[11],
  // gen_stop[12], ack_bit[13], rx_byte_valid[14], rx_byte[22:15],
  // app_events[32:23], irq_enables[35:33]
  output logic [39:0] m_axis_tdata
);
  import i2cs_pkg::*;

  q_status_t q_status;
  item_t     front_item;
  item_t     head_item;
  logic      push;
  logic      pop;
  result_t   result;

  i2cs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_status_i    (q_status),
    .push_o        (push),
    .item_o        (front_item)
  );

  i2cs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  i2cs_exec u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_status_i    (q_status),
    .item_i        (head_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .result_o      (result)
  );

  assign m_axis_tdata = {4'b0000, result};

endmodule

// ----- verif/i2c_interrupt_transfer_sequencer_tb.sv -----
`timescale 1ns / 1ps

module i2c_interrupt_transfer_sequencer_tb;
  import i2cs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 60;

  // event flag masks
  localparam logic [5:0] F_START = 6'h01;
  localparam logic [5:0] F_ADDR  = 6'h02;
  localparam logic [5:0] F_STOP  = 6'h04;
  localparam logic [5:0] F_BTF   = 6'h08;
  localparam logic [5:0] F_RXNE  = 6'h10;
  localparam logic [5:0] F_TXE   = 6'h20;

  // application event bits
  localparam int AE_TX_DONE  = 0;
  localparam int AE_RX_DONE  = 1;
  localparam int AE_DATA_REQ = 2;
  localparam int AE_DATA_RCV = 3;
  localparam int AE_STOP     = 4;
  localparam int AE_ERR_LSB  = 5;

  typedef struct {
    op_e         op;
    logic [15:0] len;
    logic [6:0]  addr;
    logic        rs;
    logic [5:0]  evt;
    logic [4:0]  err;
    logic        master;
    logic        transmitter;
    logic [7:0]  tx_data;
    logic [7:0]  rx_data;
  } req_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  i2c_interrupt_transfer_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  req_t    pend_q[$];
  result_t exp_q[$];
  req_t    cur_req;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      mismatch_cnt  = 0;
  bit      hold_req      = 1'b0;
  int      idle_cycles   = 0;

  // transfer state as the block should hold it
  xfer_state_e          xfer_st    = ST_READY;
  logic [LEN_WIDTH-1:0] bytes_left = '0;
  logic [LEN_WIDTH-1:0] rx_total   = '0;
  logic [6:0]           tgt_addr   = '0;
  logic                 keep_bus_q = 1'b0;
  logic                 ack_lvl    = 1'b1;
  logic [2:0]           irq_en     = '0;
  logic                 ack_en_cfg = 1'b1;

  function automatic result_t sequence_step(input req_t r);
    result_t res;
    res = '0;
    res.prior_state = xfer_st;
    case (r.op)
      OP_SEND, OP_RECV: begin
        if (xfer_st != ST_TX && xfer_st != ST_RX) begin
          bytes_left = LEN_WIDTH'(r.len);
          if (r.op == OP_RECV) rx_total = LEN_WIDTH'(r.len);
          tgt_addr   = r.addr & ADDR_MASK;
          keep_bus_q = r.rs;
          xfer_st    = (r.op == OP_SEND) ? ST_TX : ST_RX;
          res.gen_start = 1'b1;
          irq_en = '1;
        end
      end
      OP_EVENT: begin
        if (irq_en[EN_EVT]) begin
          if (r.evt & F_START) begin
            res.data_write_valid = 1'b1;
            res.data_write = {tgt_addr, xfer_st == ST_RX};
          end
          if ((r.evt & F_ADDR) && r.master && xfer_st == ST_RX && bytes_left == 1)
            ack_lvl = 1'b0;
          if ((r.evt & F_STOP) && xfer_st == ST_RX) res.app_events[AE_STOP] = 1'b1;
          if ((r.evt & F_BTF) && xfer_st == ST_TX && bytes_left == 0) begin
            if (!keep_bus_q) res.gen_stop = 1'b1;
            irq_en = '0;
            bytes_left = '0;
            xfer_st = ST_READY;
            res.app_events[AE_TX_DONE] = 1'b1;
          end
          if (irq_en[EN_BUF]) begin
            if (r.evt & F_RXNE) begin
              if (r.master) begin
                if (xfer_st == ST_RX) begin
                  if (rx_total == 1) begin
                    if (!keep_bus_q) res.gen_stop = 1'b1;
                    res.rx_byte_valid = 1'b1;
                    res.rx_byte = r.rx_data;
                    if (bytes_left != 0) bytes_left--;
                  end else if (rx_total > 1 && bytes_left > 0) begin
                    if (bytes_left == 2) ack_lvl = 1'b0;
                    res.rx_byte_valid = 1'b1;
                    res.rx_byte = r.rx_data;
                    if (bytes_left != 0) bytes_left--;
                  end
                  if (bytes_left == 0) begin
                    if (!keep_bus_q) res.gen_stop = 1'b1;
                    irq_en = '0;
                    bytes_left = '0;
                    rx_total = '0;
                    xfer_st = ST_READY;
                    if (ack_en_cfg) ack_lvl = 1'b1;
                    res.app_events[AE_RX_DONE] = 1'b1;
                  end
                end
              end else if (!r.transmitter) begin
                res.app_events[AE_DATA_RCV] = 1'b1;
              end
            end
            if (r.evt & F_TXE) begin
              if (r.master) begin
                if (xfer_st == ST_TX && bytes_left > 0) begin
                  res.data_write_valid = 1'b1;
                  res.data_write = r.tx_data;
                  bytes_left--;
                end
              end else if (r.transmitter) begin
                res.app_events[AE_DATA_REQ] = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        if (irq_en[EN_ERR]) res.app_events[AE_ERR_LSB +: 5] = r.err;
      end
    endcase
    res.ack_bit = ack_lvl;
    res.irq_enables = irq_en;
    return res;
  endfunction

  function automatic req_t any_req();
    req_t r;
    r.op          = op_e'($urandom_range(3));
    r.len         = 16'($urandom);
    r.addr        = 7'($urandom);
    r.rs          = 1'($urandom);
    r.evt         = 6'($urandom);
    r.err         = 5'($urandom);
    r.master      = 1'($urandom);
    r.transmitter = 1'($urandom);
    r.tx_data     = 8'($urandom);
    r.rx_data     = 8'($urandom);
    return r;
  endfunction

  function automatic req_t xfer_req(input op_e op, input logic [15:0] len,
                                    input logic [6:0] addr, input logic rs);
    req_t r;
    r = any_req();
    r.op = op;
    r.len = len;
    r.addr = addr;
    r.rs = rs;
    return r;
  endfunction

  function automatic req_t evt_req(input logic [5:0] flags, input logic m, input logic t);
    req_t r;
    r = any_req();
    r.op = OP_EVENT;
    r.evt = flags;
    r.master = m;
    r.transmitter = t;
    return r;
  endfunction

  function automatic req_t err_req(input logic [4:0] e);
    req_t r;
    r = any_req();
    r.op = OP_ERROR;
    r.err = e;
    return r;
  endfunction

  // mostly complete transfers, some cut short, some noise
  task automatic queue_random_items(input int n);
    req_t r;
    bit   rx;
    int   len;
    int   nbytes;
    while (pend_q.size() < n) begin
      if ($urandom_range(99) < 82) begin
        rx  = 1'($urandom_range(1));
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
        pend_q.push_back(xfer_req(rx ? OP_RECV : OP_SEND, 16'(len), 7'($urandom),
                                  1'($urandom)));
        pend_q.push_back(evt_req(F_START, 1'b1, !rx));
        pend_q.push_back(evt_req(F_ADDR, 1'b1, !rx));
        nbytes = (rx && len == 0) ? 1 : len;
        for (int i = 0; i < nbytes; i++) begin
          if ($urandom_range(39) == 0) break;
          if ($urandom_range(19) == 0) pend_q.push_back(err_req(5'($urandom)));
          if (rx) begin
            r = evt_req(F_RXNE, 1'b1, 1'b0);
            if (i == nbytes - 1 && $urandom_range(1)) r.evt |= F_STOP;
          end else begin
            r = evt_req(F_TXE, 1'b1, 1'b1);
          end
          pend_q.push_back(r);
        end
        if (!rx && $urandom_range(19) != 0) pend_q.push_back(evt_req(F_BTF, 1'b1, 1'b1));
      end else begin
        r = any_req();
        if (r.op == OP_SEND || r.op == OP_RECV) r.len = 16'($urandom_range(7));
        pend_q.push_back(r);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pend_q.size() != 0 || s_axis_tvalid || exp_q.size() != 0);
  endtask

  task automatic write_ack_enable(input logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ack_en_cfg = v;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // request driver
  always @(posedge clk_i) begin : req_drv
    req_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) exp_q.push_back(sequence_step(cur_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pend_q.pop_front();
          cur_req = nxt;
          s_axis_tdata  <= {3'b0, nxt.rx_data, nxt.tx_data, nxt.transmitter, nxt.master,
                            nxt.err, nxt.evt, nxt.rs, nxt.addr, nxt.len};
          s_axis_tuser  <= nxt.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready control
  always @(posedge clk_i) begin : res_mon
    result_t   got;
    result_t   want;
    static int hold_left = 0;
    static bit hold_done = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[35:0];
        if (exp_q.size() == 0) begin
          $error("result %0h with no request outstanding", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = exp_q.pop_front();
          check_field("prior_state", 16'(want.prior_state), 16'(got.prior_state));
          check_field("data_write_valid", 16'(want.data_write_valid),
                      16'(got.data_write_valid));
          check_field("data_write", 16'(want.data_write), 16'(got.data_write));
          check_field("gen_start", 16'(want.gen_start), 16'(got.gen_start));
          check_field("gen_stop", 16'(want.gen_stop), 16'(got.gen_stop));
          check_field("ack_bit", 16'(want.ack_bit), 16'(got.ack_bit));
          check_field("rx_byte_valid", 16'(want.rx_byte_valid), 16'(got.rx_byte_valid));
          check_field("rx_byte", 16'(want.rx_byte), 16'(got.rx_byte));
          check_field("app_events", 16'(want.app_events), 16'(got.app_events));
          check_field("irq_enables", 16'(want.irq_enables), 16'(got.irq_enables));
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("i2c_interrupt_transfer_sequencer_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    req_t r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_ack_enable(1'b1);

    @(negedge clk_i);
    pend_q.push_back(evt_req(6'h3F, 1'b1, 1'b1));
    pend_q.push_back(err_req(5'h1F));
    pend_q.push_back(xfer_req(OP_SEND, 16'd2, 7'h7F, 1'b0));
    pend_q.push_back(xfer_req(OP_RECV, 16'd5, 7'h00, 1'b1));
    pend_q.push_back(err_req(5'h1F));
    pend_q.push_back(evt_req(F_START, 1'b1, 1'b1));
    r = evt_req(F_TXE, 1'b1, 1'b1); r.tx_data = 8'hFF; pend_q.push_back(r);
    r = evt_req(F_TXE, 1'b1, 1'b1); r.tx_data = 8'h00; pend_q.push_back(r);
    pend_q.push_back(evt_req(F_TXE, 1'b1, 1'b1));
    pend_q.push_back(evt_req(F_BTF, 1'b1, 1'b1));
    pend_q.push_back(xfer_req(OP_RECV, 16'd3, 7'h00, 1'b1));
    pend_q.push_back(evt_req(F_START, 1'b1, 1'b0));
    pend_q.push_back(evt_req(F_ADDR, 1'b1, 1'b0));
    r = evt_req(F_RXNE, 1'b1, 1'b0); r.rx_data = 8'hFF; pend_q.push_back(r);
    r = evt_req(F_RXNE, 1'b1, 1'b0); r.rx_data = 8'h00; pend_q.push_back(r);
    r = evt_req(F_RXNE | F_STOP, 1'b1, 1'b0); r.rx_data = 8'hA5; pend_q.push_back(r);
    pend_q.push_back(xfer_req(OP_RECV, 16'd1, 7'h2A, 1'b0));
    pend_q.push_back(evt_req(F_START | F_ADDR, 1'b1, 1'b0));
    pend_q.push_back(evt_req(F_RXNE, 1'b1, 1'b0));
    pend_q.push_back(xfer_req(OP_RECV, 16'd0, 7'h11, 1'b0));
    pend_q.push_back(evt_req(F_RXNE, 1'b1, 1'b0));
    pend_q.push_back(xfer_req(OP_SEND, 16'd1, 7'h55, 1'b1));
    r = evt_req(F_START | F_TXE, 1'b1, 1'b1); r.tx_data = 8'h3C; pend_q.push_back(r);
    pend_q.push_back(evt_req(F_RXNE, 1'b0, 1'b0));
    pend_q.push_back(evt_req(F_TXE, 1'b0, 1'b1));
    pend_q.push_back(evt_req(F_BTF, 1'b1, 1'b1));
    wait_idle();

    write_ack_enable(1'b0);
    @(negedge clk_i);
    send_idle_pct = 29;
    recv_idle_pct = 53;
    queue_random_items(140);
    wait_idle();
    queue_random_items(140);
    wait_idle();

    write_ack_enable(1'b1);
    @(negedge clk_i);
    send_idle_pct = 53;
    recv_idle_pct = 29;
    queue_random_items(280);
    wait_idle();

    write_ack_enable(1'b0);
    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_items(290);
    hold_req = 1'b1;
    wait_idle();

    // finish any open transfer, then a maximum-length receive
    if (xfer_st == ST_TX) begin
      repeat (bytes_left) pend_q.push_back(evt_req(F_TXE, 1'b1, 1'b1));
      pend_q.push_back(evt_req(F_BTF, 1'b1, 1'b1));
    end else if (xfer_st == ST_RX) begin
      repeat ((bytes_left == 0) ? 1 : bytes_left)
        pend_q.push_back(evt_req(F_RXNE, 1'b1, 1'b0));
    end
    wait_idle();
    pend_q.push_back(xfer_req(OP_RECV, 16'hFFFF, 7'h7F, 1'b0));
    pend_q.push_back(evt_req(F_START | F_ADDR, 1'b1, 1'b0));
    repeat (4) pend_q.push_back(evt_req(F_RXNE, 1'b1, 1'b0));
    wait_idle();

    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("i2c_interrupt_transfer_sequencer_tb: PASS");
    end else begin
      $display("i2c_interrupt_transfer_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
